>>> sv/dic_pkg.sv
package dic_pkg;

    // Oscillator geometry
    localparam int TABLE_BITS = 8;
    localparam int PHASE_BITS = 32;
    localparam int TBL_LEN    = 1 << TABLE_BITS;
    localparam int QUARTER    = TBL_LEN >> 2;
    localparam int EIGHTH     = TBL_LEN >> 3;

    // Field and datapath widths
    localparam int STEP_W     = 32;
    localparam int RECIP_W    = 25;
    localparam int SAMPLE_W   = 16;
    localparam int TRIG_W     = 16;
    localparam int AMP_W      = 34;
    localparam int OUT_W      = 8;
    localparam int OUT_SHIFT  = 24;
    localparam int SUM_W      = OUT_SHIFT + OUT_W;
    localparam int SLOPE_SHIFT = 8;
    localparam int AMP_SHIFT  = 16;
    localparam int KSCALE_W   = 16;
    localparam int SCALE_SHIFT = 31;
    localparam int PROD_W     = AMP_W + KSCALE_W;
    localparam int SCALED_W   = PROD_W - SCALE_SHIFT - 1;
    localparam int MIX_W      = SCALED_W + TRIG_W;
    localparam int DIFF_W     = SAMPLE_W + 1;
    localparam int SPROD_W    = DIFF_W + RECIP_W + 1;

    localparam logic signed [KSCALE_W-1:0] INV_SQRT2_K = 16'sd23170;

    // Configuration port
    localparam int ADDR_W = 3;
    localparam int DATA_W = 32;
    localparam logic [STEP_W-1:0]  TUNING_WORD_RST = 32'd64424509;
    localparam logic [RECIP_W-1:0] RATIO_RECIP_RST = 25'd8389;

    typedef enum logic {
        REG_TUNING_WORD = 1'b0,
        REG_RATIO_RECIP = 1'b1
    } dic_reg_idx_t;

    // Commands from the controller to the datapath
    typedef struct packed {
        logic start;
        logic load;
        logic scale;
        logic mix;
        logic finish;
    } dic_cmd_t;

    typedef logic [2*TRIG_W-1:0] trig_rom_t [TBL_LEN];

    // Table construction, evaluated at elaboration only.
    localparam logic [63:0] ONE_Q61    = 64'h2000_0000_0000_0000;
    localparam logic [63:0] TWO_PI_Q61 = 64'hC90F_DAA2_2168_C234;
    localparam logic [63:0] UNIT_Q61   = TWO_PI_Q61 >> TABLE_BITS;

    function automatic logic [63:0] mul_shift(logic [63:0] a, logic [63:0] b);
        logic [127:0] p;
        p = {64'd0, a} * {64'd0, b};
        p = p >> 61;
        return p[63:0];
    endfunction

    // Restoring long division; the divisor here is always small.
    function automatic logic [63:0] long_div(logic [63:0] num, logic [63:0] den);
        logic [63:0] quo;
        logic [63:0] rem;
        quo = '0;
        rem = '0;
        for (int b = 63; b >= 0; b--)
        begin
            rem = {rem[62:0], num[b]};
            if (rem >= den)
            begin
                rem    = rem - den;
                quo[b] = 1'b1;
            end
        end
        return quo;
    endfunction

    function automatic logic [63:0] taylor(logic [63:0] x, logic want_cos);
        logic [63:0] x2;
        logic [63:0] term;
        logic [63:0] sum;
        logic [63:0] n;
        logic        neg;
        x2   = mul_shift(x, x);
        term = want_cos ? ONE_Q61 : x;
        sum  = term;
        n    = want_cos ? 64'd1 : 64'd2;
        neg  = 1'b1;
        while (term != 64'd0 && n < 64'd60)
        begin
            term = long_div(mul_shift(term, x2), n * (n + 64'd1));
            sum  = neg ? sum - term : sum + term;
            neg  = !neg;
            n    = n + 64'd2;
        end
        return sum;
    endfunction

    function automatic logic [TRIG_W-1:0] quarter_sin(int unsigned r);
        logic [63:0] v;
        logic [63:0] m;
        if (r <= EIGHTH)
        begin
            v = taylor(UNIT_Q61 * 64'(r), 1'b0);
        end
        else
        begin
            v = taylor(UNIT_Q61 * 64'(QUARTER - r), 1'b1);
        end
        m = mul_shift(v, 64'd32767);
        return m[TRIG_W-1:0];
    endfunction

    function automatic logic [TRIG_W-1:0] table_sin(int unsigned i);
        int unsigned       q;
        int unsigned       r;
        logic [TRIG_W-1:0] mag;
        q   = (i >> (TABLE_BITS - 2)) & 3;
        r   = i & (QUARTER - 1);
        mag = q[0] ? quarter_sin(QUARTER - r) : quarter_sin(r);
        return q[1] ? (TRIG_W'(0) - mag) : mag;
    endfunction

    function automatic trig_rom_t build_trig_rom();
        trig_rom_t rom;
        for (int unsigned i = 0; i < TBL_LEN; i++)
        begin
            rom[i] = {table_sin(i), table_sin((i + QUARTER) & (TBL_LEN - 1))};
        end
        return rom;
    endfunction

    // Sine in the upper half of each entry, cosine in the lower half.
    localparam trig_rom_t TRIG_ROM = build_trig_rom();

endpackage

>>> sv/dds_iq_upconverter.sv
// I/Q upconverter built around a numerically controlled oscillator.
// Input channel (in_valid/in_ready): each item carries mode, sample_i and
// sample_q. With mode set, the item starts a new baseband segment that ramps
// linearly from the previous sample toward the new one; with mode clear the
// ramp continues and the sample fields are ignored.
// Output channel (out_valid/out_ready): exactly one signed dac_sample per item,
// in input order.
// Configuration goes through the APB port: the tuning word (phase increment per
// output) at byte address 0 and ratio_reciprocal (Q24) at byte address 4.
// Write only while no item is in flight.
// The controller steps each accepted item through the load, scale, mix and output
// stages in turn before its result is offered; a new item is accepted only once the
// current one has left its output stage.
// A finished result waits in the output register; the next item is accepted
// meanwhile and holds in its last stage until the receiver takes the result.
// Reset clears the phase accumulator, amplitudes, slopes and previous samples,
// loads the register defaults and empties the output.
module dds_iq_upconverter (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 in_valid,
    output logic                                 in_ready,
    input  logic                                 mode,
    input  logic signed [dic_pkg::SAMPLE_W-1:0]  sample_i,
    input  logic signed [dic_pkg::SAMPLE_W-1:0]  sample_q,
    output logic                                 out_valid,
    input  logic                                 out_ready,
    output logic signed [dic_pkg::OUT_W-1:0]     dac_sample,
    input  logic                                 psel,
    input  logic                                 penable,
    input  logic                                 pwrite,
    input  logic [dic_pkg::ADDR_W-1:0]           paddr,
    input  logic [dic_pkg::DATA_W-1:0]           pwdata,
    output logic [dic_pkg::DATA_W-1:0]           prdata,
    output logic                                 pready
);
    import dic_pkg::*;

    logic [STEP_W-1:0]  tuning_word;
    logic [RECIP_W-1:0] ratio_recip;
    dic_cmd_t           cmd;

    dic_regs u_regs (
        .clk         (clk),
        .rst_n       (rst_n),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready),
        .tuning_word (tuning_word),
        .ratio_recip (ratio_recip)
    );

    dic_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .cmd       (cmd)
    );

    dic_datapath u_datapath (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .mode        (mode),
        .sample_i    (sample_i),
        .sample_q    (sample_q),
        .tuning_word (tuning_word),
        .ratio_recip (ratio_recip),
        .dac_sample  (dac_sample)
    );

endmodule

>>> sv/dic_regs.sv
module dic_regs (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [dic_pkg::ADDR_W-1:0]    paddr,
    input  logic [dic_pkg::DATA_W-1:0]    pwdata,
    output logic [dic_pkg::DATA_W-1:0]    prdata,
    output logic                          pready,
    output logic [dic_pkg::STEP_W-1:0]    tuning_word,
    output logic [dic_pkg::RECIP_W-1:0]   ratio_recip
);
    import dic_pkg::*;

    logic [STEP_W-1:0]  tuning_word_reg;
    logic [RECIP_W-1:0] ratio_recip_reg;
    dic_reg_idx_t       reg_idx;
    logic               wr_en;

    // Registers are word aligned; the low address bits are not decoded.
    assign reg_idx = dic_reg_idx_t'(paddr[ADDR_W-1]);
    assign wr_en   = psel && penable && pwrite;
    assign pready  = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tuning_word_reg <= TUNING_WORD_RST;
            ratio_recip_reg <= RATIO_RECIP_RST;
        end
        else if (wr_en)
        begin
            case (reg_idx)
                REG_TUNING_WORD: tuning_word_reg <= pwdata[STEP_W-1:0];
                REG_RATIO_RECIP: ratio_recip_reg <= pwdata[RECIP_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        case (reg_idx)
            REG_TUNING_WORD: prdata = DATA_W'(tuning_word_reg);
            REG_RATIO_RECIP: prdata = DATA_W'(ratio_recip_reg);
            default:         prdata = '0;
        endcase
    end

    assign tuning_word = tuning_word_reg;
    assign ratio_recip = ratio_recip_reg;

endmodule

>>> sv/dic_datapath.sv
module dic_datapath (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  dic_pkg::dic_cmd_t                    cmd,
    input  logic                                 mode,
    input  logic signed [dic_pkg::SAMPLE_W-1:0]  sample_i,
    input  logic signed [dic_pkg::SAMPLE_W-1:0]  sample_q,
    input  logic [dic_pkg::STEP_W-1:0]           tuning_word,
    input  logic [dic_pkg::RECIP_W-1:0]          ratio_recip,
    output logic signed [dic_pkg::OUT_W-1:0]     dac_sample
);
    import dic_pkg::*;

    // Item latched at acceptance
    logic                       mode_reg;
    logic signed [SAMPLE_W-1:0] new_i_reg;
    logic signed [SAMPLE_W-1:0] new_q_reg;
    logic [2*TRIG_W-1:0]        entry_reg;

    // Oscillator and interpolator state
    logic [PHASE_BITS-1:0]      phase_acc_reg;
    logic signed [AMP_W-1:0]    amp_i_reg;
    logic signed [AMP_W-1:0]    amp_q_reg;
    logic signed [AMP_W-1:0]    slope_i_reg;
    logic signed [AMP_W-1:0]    slope_q_reg;
    logic signed [SAMPLE_W-1:0] prev_i_reg;
    logic signed [SAMPLE_W-1:0] prev_q_reg;

    // Pipeline registers
    logic signed [PROD_W-1:0]   prod_i_reg;
    logic signed [PROD_W-1:0]   prod_q_reg;
    logic signed [MIX_W-1:0]    mix_i_reg;
    logic signed [MIX_W-1:0]    mix_q_reg;
    logic signed [OUT_W-1:0]    dac_reg;

    logic signed [DIFF_W-1:0]   diff_i;
    logic signed [DIFF_W-1:0]   diff_q;
    logic signed [SPROD_W-1:0]  sprod_i;
    logic signed [SPROD_W-1:0]  sprod_q;
    logic signed [SCALED_W-1:0] scaled_i;
    logic signed [SCALED_W-1:0] scaled_q;
    logic [SUM_W-1:0]           sum;

    // Quotient by 2^31 rounded toward zero: floor, plus one for an inexact negative value.
    function automatic logic signed [SCALED_W-1:0] trunc_scale(logic signed [PROD_W-1:0] p);
        logic inc;
        inc = p[PROD_W-1] && (|p[SCALE_SHIFT-1:0]);
        return p[SCALE_SHIFT +: SCALED_W] + SCALED_W'(inc);
    endfunction

    assign diff_i  = DIFF_W'(new_i_reg) - DIFF_W'(prev_i_reg);
    assign diff_q  = DIFF_W'(new_q_reg) - DIFF_W'(prev_q_reg);
    assign sprod_i = diff_i * $signed({1'b0, ratio_recip});
    assign sprod_q = diff_q * $signed({1'b0, ratio_recip});

    assign scaled_i = trunc_scale(prod_i_reg);
    assign scaled_q = trunc_scale(prod_q_reg);

    // Only the bits up to the output byte matter, so the sum stays narrow.
    assign sum = mix_i_reg[SUM_W-1:0] + mix_q_reg[SUM_W-1:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_acc_reg <= '0;
            amp_i_reg     <= '0;
            amp_q_reg     <= '0;
            slope_i_reg   <= '0;
            slope_q_reg   <= '0;
            prev_i_reg    <= '0;
            prev_q_reg    <= '0;
        end
        else
        begin
            if (cmd.start)
            begin
                phase_acc_reg <= phase_acc_reg + tuning_word[PHASE_BITS-1:0];
            end
            if (cmd.load && mode_reg)
            begin
                amp_i_reg   <= {AMP_W'(prev_i_reg)} << AMP_SHIFT;
                amp_q_reg   <= {AMP_W'(prev_q_reg)} << AMP_SHIFT;
                slope_i_reg <= sprod_i[SLOPE_SHIFT +: AMP_W];
                slope_q_reg <= sprod_q[SLOPE_SHIFT +: AMP_W];
                prev_i_reg  <= new_i_reg;
                prev_q_reg  <= new_q_reg;
            end
            if (cmd.finish)
            begin
                amp_i_reg <= amp_i_reg + slope_i_reg;
                amp_q_reg <= amp_q_reg + slope_q_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.start)
        begin
            mode_reg  <= mode;
            new_i_reg <= sample_i;
            new_q_reg <= sample_q;
            entry_reg <= TRIG_ROM[phase_acc_reg[PHASE_BITS-1 -: TABLE_BITS]];
        end
        if (cmd.scale)
        begin
            prod_i_reg <= amp_i_reg * INV_SQRT2_K;
            prod_q_reg <= amp_q_reg * INV_SQRT2_K;
        end
        if (cmd.mix)
        begin
            mix_i_reg <= scaled_i * $signed(entry_reg[2*TRIG_W-1:TRIG_W]);
            mix_q_reg <= scaled_q * $signed(entry_reg[TRIG_W-1:0]);
        end
        if (cmd.finish)
        begin
            dac_reg <= sum[OUT_SHIFT +: OUT_W];
        end
    end

    assign dac_sample = dac_reg;

endmodule

>>> sv/dic_ctrl.sv
module dic_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    output logic              out_valid,
    input  logic              out_ready,
    output dic_pkg::dic_cmd_t cmd
);
    import dic_pkg::*;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_LOAD,
        ST_SCALE,
        ST_MIX,
        ST_DONE
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   out_valid_reg;
    logic   out_valid_next;

    assign in_ready   = (state_reg == ST_IDLE);
    assign out_valid  = out_valid_reg;

    always_comb begin
        cmd.start  = in_valid && (state_reg == ST_IDLE);
        cmd.load   = (state_reg == ST_LOAD);
        cmd.scale  = (state_reg == ST_SCALE);
        cmd.mix    = (state_reg == ST_MIX);
        // The output register may be refilled in the same cycle its item leaves.
        cmd.finish = (state_reg == ST_DONE) && (!out_valid_reg || out_ready);
    end

    always_comb begin
        state_next     = state_reg;
        out_valid_next = out_valid_reg;
        if (out_ready) begin
            out_valid_next = 1'b0;
        end
        case (state_reg)
            ST_IDLE:  if (in_valid) state_next = ST_LOAD;
            ST_LOAD:  state_next = ST_SCALE;
            ST_SCALE: state_next = ST_MIX;
            ST_MIX:   state_next = ST_DONE;
            ST_DONE:
                begin
                    if (cmd.finish) begin
                        state_next     = ST_IDLE;
                        out_valid_next = 1'b1;
                    end
                end
            default:  state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

`ifndef ASSERT_OFF
    a_accept_then_load: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.start |=> cmd.load)
        else $error("accepted item was not followed by the load step");

    a_one_item_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> !in_ready)
        else $error("input ready while an item is in progress");

    a_result_from_done: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg == ST_DONE))
        else $error("result appeared without a finished item");

    a_stall_holds_done: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DONE && out_valid_reg && !out_ready) |=> state_reg == ST_DONE)
        else $error("finished item left while the output was still occupied");
`endif

endmodule

>>> dv/dds_iq_upconverter_checker.sv
`timescale 1ns / 1ps

module dds_iq_upconverter_checker (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 in_valid,
    input  logic                                 in_ready,
    input  logic                                 mode,
    input  logic signed [dic_pkg::SAMPLE_W-1:0]  sample_i,
    input  logic signed [dic_pkg::SAMPLE_W-1:0]  sample_q,
    input  logic                                 out_valid,
    input  logic                                 out_ready,
    input  logic signed [dic_pkg::OUT_W-1:0]     dac_sample,
    input  logic                                 psel,
    input  logic                                 penable,
    input  logic                                 pwrite,
    input  logic [dic_pkg::ADDR_W-1:0]           paddr,
    input  logic [dic_pkg::DATA_W-1:0]           pwdata,
    input  logic [dic_pkg::DATA_W-1:0]           prdata,
    input  logic                                 pready,
    output int                                   fail_count,
    output int                                   pending
);

    localparam int  LUT_SIZE   = 256;
    localparam int  LUT_QUART  = LUT_SIZE / 4;
    localparam real TWO_PI     = 6.283185307179586;
    localparam longint IQ_GAIN = 23170;
    localparam logic [31:0] STEP_AT_RESET  = 32'd64424509;
    localparam logic [24:0] RECIP_AT_RESET = 25'd8389;

    logic signed [15:0] sine_tab [LUT_SIZE];
    logic signed [15:0] cosine_tab [LUT_SIZE];

    // Oscillator and amplitude ramp state
    logic [31:0]        nco_phase;
    logic [33:0]        amp_i;
    logic [33:0]        amp_q;
    logic [33:0]        slope_i;
    logic [33:0]        slope_q;
    logic signed [15:0] last_i;
    logic signed [15:0] last_q;
    logic [31:0]        step_reg;
    logic [24:0]        recip_reg;

    logic signed [7:0]  expected_dac [$];
    int                 mismatches = 0;
    int                 results_seen = 0;

    // Magnitude from the first quadrant, sign from the quadrant, truncated toward zero.
    function automatic logic signed [15:0] trunc_sine(int k);
        int quad;
        int r;
        int mag;
        quad = (k / LUT_QUART) % 4;
        r    = k % LUT_QUART;
        if (quad % 2 == 1)
        begin
            r = LUT_QUART - r;
        end
        mag = $rtoi(32767.0 * $sin(TWO_PI * r / LUT_SIZE));
        return (quad >= 2) ? 16'(-mag) : 16'(mag);
    endfunction

    initial
    begin
        for (int k = 0; k < LUT_SIZE; k++)
        begin
            sine_tab[k]   = trunc_sine(k);
            cosine_tab[k] = trunc_sine((k + LUT_QUART) % LUT_SIZE);
        end
    end

    function automatic logic [33:0] ramp_slope(logic signed [15:0] target,
                                               logic signed [15:0] origin);
        longint prod;
        prod = (longint'(target) - longint'(origin)) * longint'(recip_reg);
        return 34'(prod >>> 8);
    endfunction

    function automatic longint scaled_amp(logic [33:0] amp);
        longint a;
        a = longint'(signed'(amp));
        return (a * IQ_GAIN) / (longint'(1) <<< 31);
    endfunction

    task automatic modulate_item(input logic ld, input logic signed [15:0] si,
                                 input logic signed [15:0] sq,
                                 output logic signed [7:0] dac);
        logic [7:0] slot;
        longint     mix;
        if (ld)
        begin
            // The ramp restarts at the previous sample and heads for the new one.
            amp_i   = {{2{last_i[15]}}, last_i, 16'd0};
            amp_q   = {{2{last_q[15]}}, last_q, 16'd0};
            slope_i = ramp_slope(si, last_i);
            slope_q = ramp_slope(sq, last_q);
            last_i  = si;
            last_q  = sq;
        end
        slot      = nco_phase[31:24];
        nco_phase = nco_phase + step_reg;
        mix = scaled_amp(amp_i) * longint'(sine_tab[slot])
            + scaled_amp(amp_q) * longint'(cosine_tab[slot]);
        dac   = mix[31:24];
        amp_i = amp_i + slope_i;
        amp_q = amp_q + slope_q;
    endtask

    task automatic note_fault(input string what, input longint want, input longint got);
        mismatches++;
        if (mismatches <= 10)
        begin
            $display("%0t: %s: expected %0d, got %0d", $realtime, what, want, got);
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        logic signed [7:0] want;
        logic [31:0]       reg_value;
        dic_pkg::dic_reg_idx_t sel;
        if (!rst_n)
        begin
            nco_phase = '0;
            amp_i     = '0;
            amp_q     = '0;
            slope_i   = '0;
            slope_q   = '0;
            last_i    = '0;
            last_q    = '0;
            step_reg  = STEP_AT_RESET;
            recip_reg = RECIP_AT_RESET;
            expected_dac.delete();
            fail_count <= mismatches;
            pending    <= 0;
        end
        else
        begin
            if (psel && penable && pready)
            begin
                sel = dic_pkg::dic_reg_idx_t'(paddr[2]);
                if (pwrite)
                begin
                    case (sel)
                        dic_pkg::REG_TUNING_WORD: step_reg  = pwdata;
                        dic_pkg::REG_RATIO_RECIP: recip_reg = pwdata[24:0];
                        default: ;
                    endcase
                end
                else
                begin
                    reg_value = (sel == dic_pkg::REG_TUNING_WORD) ? step_reg
                                                                  : {7'd0, recip_reg};
                    if (prdata !== reg_value)
                    begin
                        note_fault($sformatf("register readback at %0d", paddr),
                                   reg_value, prdata);
                    end
                end
            end
            if (in_valid && in_ready)
            begin
                modulate_item(mode, sample_i, sample_q, want);
                expected_dac.push_back(want);
            end
            if (out_valid && out_ready)
            begin
                results_seen++;
                if (expected_dac.size() == 0)
                begin
                    note_fault($sformatf("unexpected dac_sample, result %0d", results_seen),
                               0, dac_sample);
                end
                else
                begin
                    want = expected_dac.pop_front();
                    if (dac_sample !== want)
                    begin
                        note_fault($sformatf("dac_sample of result %0d", results_seen),
                                   want, dac_sample);
                    end
                end
            end
            fail_count <= mismatches;
            pending    <= expected_dac.size();
        end
    end

endmodule

>>> dv/dds_iq_upconverter_tb.sv
`timescale 1ns / 1ps

module dds_iq_upconverter_tb;

    import dic_pkg::*;

    localparam int CYCLE_LIMIT = 400000;
    localparam int SETTLE_CYCLES = 12;

    logic                        clk;
    logic                        rst_n;
    logic                        in_valid;
    logic                        in_ready;
    logic                        mode;
    logic signed [SAMPLE_W-1:0]  sample_i;
    logic signed [SAMPLE_W-1:0]  sample_q;
    logic                        out_valid;
    logic                        out_ready;
    logic signed [OUT_W-1:0]     dac_sample;
    logic                        psel;
    logic                        penable;
    logic                        pwrite;
    logic [ADDR_W-1:0]           paddr;
    logic [DATA_W-1:0]           pwdata;
    logic [DATA_W-1:0]           prdata;
    logic                        pready;

    int fail_count;
    int pending;
    int cycles = 0;
    int gap_pct = 0;
    int stall_pct = 0;
    int outputs_per_sample = 1;

    dds_iq_upconverter DUT (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .mode       (mode),
        .sample_i   (sample_i),
        .sample_q   (sample_q),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .dac_sample (dac_sample),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready)
    );

    dds_iq_upconverter_checker checker_i (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .mode       (mode),
        .sample_i   (sample_i),
        .sample_q   (sample_q),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .dac_sample (dac_sample),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready),
        .fail_count (fail_count),
        .pending    (pending)
    );

    always
    begin
        clk = 1'b0;
        #2;
        clk = 1'b1;
        #2;
    end

    always @(posedge clk)
    begin
        out_ready <= ($urandom_range(99) >= stall_pct);
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("dds_iq_upconverter_tb: done, errors");
            $finish;
        end
    end

    function automatic logic signed [15:0] pick_sample();
        case ($urandom_range(9))
            0: return 16'sh7fff;
            1: return 16'sh8000;
            2: return 16'sh0000;
            3: return 16'shffff;
            default: return 16'($urandom);
        endcase
    endfunction

    task automatic send_item(input logic ld, input logic signed [15:0] si,
                             input logic signed [15:0] sq);
        int gap;
        gap = 0;
        while ($urandom_range(99) < gap_pct)
        begin
            gap++;
        end
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        mode     <= ld;
        sample_i <= si;
        sample_q <= sq;
        do @(posedge clk); while (!in_ready);
    endtask

    // Registers may only change with nothing in flight.
    task automatic settle();
        in_valid <= 1'b0;
        do @(posedge clk); while (pending != 0);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic apb_access(input logic wr, input dic_reg_idx_t sel,
                              input logic [31:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= wr;
        paddr   <= {sel, 2'b00};
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge clk);
    endtask

    task automatic load_config(input logic [31:0] step, input logic [24:0] recip);
        apb_access(1'b1, REG_TUNING_WORD, step);
        apb_access(1'b1, REG_RATIO_RECIP, {7'd0, recip});
        apb_access(1'b0, REG_TUNING_WORD, '0);
        apb_access(1'b0, REG_RATIO_RECIP, '0);
    endtask

    task automatic pick_config();
        logic [31:0] step;
        logic [24:0] recip;
        case ($urandom_range(4))
            0: step = 32'd0;
            1: step = 32'hffff_ffff;
            2: step = $urandom;
            default: step = $urandom_range(1, 32'h0400_0000);
        endcase
        case ($urandom_range(5))
            0:
            begin
                recip = 25'd0;
                outputs_per_sample = $urandom_range(1, 12);
            end
            1:
            begin
                recip = 25'h100_0000;
                outputs_per_sample = 1;
            end
            2:
            begin
                recip = 25'h1ff_ffff;
                outputs_per_sample = $urandom_range(1, 12);
            end
            default:
            begin
                outputs_per_sample = $urandom_range(1, 32);
                recip = 25'(32'h100_0000 / outputs_per_sample);
            end
        endcase
        load_config(step, recip);
    endtask

    // Mostly whole segments (a new sample, then ramp steps), with some noise items.
    task automatic run_segment(input int count);
        int sent;
        sent = 0;
        while (sent < count)
        begin
            if ($urandom_range(99) < 85)
            begin
                send_item(1'b1, pick_sample(), pick_sample());
                sent++;
                for (int k = 1; k < outputs_per_sample; k++)
                begin
                    send_item(1'b0, 16'($urandom), 16'($urandom));
                    sent++;
                end
            end
            else
            begin
                send_item(1'($urandom), pick_sample(), pick_sample());
                sent++;
            end
        end
    endtask

    initial
    begin
        rst_n     <= 1'b0;
        in_valid  <= 1'b0;
        mode      <= 1'b0;
        sample_i  <= '0;
        sample_q  <= '0;
        out_ready <= 1'b0;
        psel      <= 1'b0;
        penable   <= 1'b0;
        pwrite    <= 1'b0;
        paddr     <= '0;
        pwdata    <= '0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        gap_pct   = 37;
        stall_pct = 57;
        apb_access(1'b0, REG_TUNING_WORD, '0);
        apb_access(1'b0, REG_RATIO_RECIP, '0);

        // Default settings; the sample fields of a ramp item must not matter.
        send_item(1'b1, 16'sh7fff, 16'sh7fff);
        send_item(1'b0, 16'shffff, 16'sh0000);
        send_item(1'b0, 16'sh0000, 16'sh0000);
        send_item(1'b1, 16'sh8000, 16'sh8000);
        send_item(1'b1, 16'sh0000, 16'shffff);
        send_item(1'b0, 16'sh5555, 16'shaaaa);
        settle();

        // Oversized reciprocal: slopes and amplitudes wrap, the output wraps too.
        load_config(32'hffff_ffff, 25'h1ff_ffff);
        send_item(1'b1, 16'sh7fff, 16'sh8000);
        send_item(1'b1, 16'sh8000, 16'sh7fff);
        repeat (6) send_item(1'b0, 16'($urandom), 16'($urandom));
        settle();

        load_config(32'd0, 25'd0);
        send_item(1'b1, 16'sd12345, -16'sd12345);
        send_item(1'b0, 16'($urandom), 16'($urandom));
        send_item(1'b1, 16'shffff, 16'sh0001);
        settle();

        load_config(32'h8000_0000, 25'h100_0000);
        send_item(1'b1, 16'sh8000, 16'sh7fff);
        send_item(1'b1, 16'sh7fff, 16'sh8000);
        repeat (3) send_item(1'b0, 16'($urandom), 16'($urandom));
        settle();

        for (int phase = 0; phase < 3; phase++)
        begin
            gap_pct   = (phase == 0) ? 37 : (phase == 1) ? 57 : 0;
            stall_pct = (phase == 0) ? 57 : (phase == 1) ? 37 : 0;
            repeat (3)
            begin
                pick_config();
                run_segment(90);
                settle();
            end
        end

        if (fail_count == 0 && pending == 0)
        begin
            $display("dds_iq_upconverter_tb: done, clean");
        end
        else
        begin
            $display("dds_iq_upconverter_tb: done, errors");
        end
        $finish;
    end

endmodule

>>> filelist.f
sv/dic_pkg.sv
sv/dic_regs.sv
sv/dic_datapath.sv
sv/dic_ctrl.sv
sv/dds_iq_upconverter.sv
dv/dds_iq_upconverter_checker.sv
dv/dds_iq_upconverter_tb.sv
